/* design/can_frame_ascii_encoder_assert.svh */
// ----------------------------------------------------------------------------
// can_frame_ascii_encoder assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_ASCII_ENCODER_ASSERT_SVH
`define CAN_FRAME_ASCII_ENCODER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ACFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ACFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ACFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ACFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* design/acfe_pkg.sv */
// ----------------------------------------------------------------------------
// acfe_pkg
// types, constants and character helpers of the can frame ascii encoder
// ----------------------------------------------------------------------------
package acfe_pkg;

    localparam int NUM_CELLS = 27;
    localparam int POS_W     = 5;

    localparam logic [7:0] TERM_RESET    = 8'd13;
    localparam logic [3:0] MAX_BYTES     = 4'd8;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_EXT_DATA = 8'h54;
    localparam logic [7:0] CHAR_STD_DATA = 8'h74;
    localparam logic [7:0] CHAR_EXT_RMT  = 8'h52;
    localparam logic [7:0] CHAR_STD_RMT  = 8'h72;

    typedef enum logic [1:0] {
        FT_EXT_DATA = 2'd0,
        FT_STD_DATA = 2'd1,
        FT_EXT_RMT  = 2'd2,
        FT_STD_RMT  = 2'd3
    } t_frame_type;

    typedef struct packed {
        t_frame_type frame_type;
        logic [28:0] identifier;
        logic [3:0]  data_length;
        logic [7:0]  data_byte_0;
        logic [7:0]  data_byte_1;
        logic [7:0]  data_byte_2;
        logic [7:0]  data_byte_3;
        logic [7:0]  data_byte_4;
        logic [7:0]  data_byte_5;
        logic [7:0]  data_byte_6;
        logic [7:0]  data_byte_7;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] ch;
    } t_cell;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        return (nib > 4'd9) ? ({4'h0, nib} - 8'd10 + CHAR_LOWER_A) : ({4'h0, nib} + CHAR_ZERO);
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        return (nib > 4'd9) ? ({4'h0, nib} - 8'd10 + CHAR_UPPER_A) : ({4'h0, nib} + CHAR_ZERO);
    endfunction

    function automatic logic [7:0] type_letter(input t_frame_type ft);
        logic [7:0] c;
        case (ft)
            FT_EXT_DATA: c = CHAR_EXT_DATA;
            FT_STD_DATA: c = CHAR_STD_DATA;
            FT_EXT_RMT:  c = CHAR_EXT_RMT;
            FT_STD_RMT:  c = CHAR_STD_RMT;
            default:     c = CHAR_EXT_DATA;
        endcase
        return c;
    endfunction

endpackage

/* design/acfe_cell.sv */
// ----------------------------------------------------------------------------
// acfe_cell
// one character cell of the output chain, loads in parallel or shifts
// ----------------------------------------------------------------------------
module acfe_cell
    import acfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cell      i_load_cell,
    input  t_cell      i_next_cell,
    output t_cell      o_cell
);

    logic       r_valid, n_valid;
    logic       r_last, n_last;
    logic [7:0] r_ch, n_ch;

    always_comb begin
        n_valid = r_valid;
        n_last  = r_last;
        n_ch    = r_ch;
        if (i_ctrl.load) begin
            n_valid = i_load_cell.valid;
            n_last  = i_load_cell.last;
            n_ch    = i_load_cell.ch;
        end else if (i_ctrl.shift) begin
            n_valid = i_next_cell.valid;
            n_last  = i_next_cell.last;
            n_ch    = i_next_cell.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_ch   <= n_ch;
    end

    assign o_cell = '{valid: r_valid, last: r_last, ch: r_ch};

endmodule

/* design/acfe_fmt.sv */
// ----------------------------------------------------------------------------
// acfe_fmt
// lays out the text of one frame over the cell positions
// ----------------------------------------------------------------------------
module acfe_fmt
    import acfe_pkg::*;
(
    input  t_in_item                   i_item,
    input  logic [7:0]                 i_term,
    output t_cell [NUM_CELLS-1:0]      o_cells
);

    logic             ext;
    logic             is_data;
    logic [3:0]       len_sat;
    logic [POS_W-1:0] len_pos;
    logic [POS_W-1:0] term_pos;
    logic [31:0]      id_word;
    logic [7:0]       bytes [8];

    assign ext     = (i_item.frame_type == FT_EXT_DATA) || (i_item.frame_type == FT_EXT_RMT);
    assign is_data = (i_item.frame_type == FT_EXT_DATA) || (i_item.frame_type == FT_STD_DATA);
    assign len_sat = (i_item.data_length > MAX_BYTES) ? MAX_BYTES : i_item.data_length;
    assign len_pos = ext ? POS_W'(9) : POS_W'(4);
    assign term_pos = len_pos + POS_W'(1) + (is_data ? {len_sat, 1'b0} : POS_W'(0));
    assign id_word = ext ? {3'b000, i_item.identifier} : {21'd0, i_item.identifier[10:0]};

    assign bytes[0] = i_item.data_byte_0;
    assign bytes[1] = i_item.data_byte_1;
    assign bytes[2] = i_item.data_byte_2;
    assign bytes[3] = i_item.data_byte_3;
    assign bytes[4] = i_item.data_byte_4;
    assign bytes[5] = i_item.data_byte_5;
    assign bytes[6] = i_item.data_byte_6;
    assign bytes[7] = i_item.data_byte_7;

    always_comb begin
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] nib_off;
        logic [POS_W-1:0] d;
        logic [3:0]       nib;
        logic [7:0]       b;
        for (int p = 0; p < NUM_CELLS; p++) begin
            pos     = POS_W'(p);
            nib_off = len_pos - POS_W'(1) - pos;
            nib     = id_word[nib_off[2:0]*4 +: 4];
            d       = pos - len_pos - POS_W'(1);
            b       = bytes[d[3:1]];
            o_cells[p].valid = (pos <= term_pos);
            o_cells[p].last  = (pos == term_pos);
            if (pos == '0) begin
                o_cells[p].ch = type_letter(i_item.frame_type);
            end else if (pos < len_pos) begin
                o_cells[p].ch = hex_lower(nib);
            end else if (pos == len_pos) begin
                o_cells[p].ch = {4'h0, len_sat} + CHAR_ZERO;
            end else if (pos < term_pos) begin
                // high digit on even offsets
                o_cells[p].ch = d[0] ? hex_upper(b[3:0]) : hex_upper(b[7:4]);
            end else begin
                o_cells[p].ch = i_term;
            end
        end
    end

endmodule

/* design/can_frame_ascii_encoder.sv */
// ----------------------------------------------------------------------------
// can_frame_ascii_encoder
// encodes one can frame per transfer into slcan style ascii text
// ----------------------------------------------------------------------------
// A frame transfer is laid out at once into a chain of 27 character cells;
// the chain then shifts one cell toward the output every cycle the head
// character is taken, so the text streams out at one character per cycle
// while i_ready holds. The text of a frame is 6 to 27 characters long
// (standard remote: 6, extended data with 8 bytes: 27). The next frame is
// taken in the cycle the last character of the previous one leaves, so
// frames stream without a gap.
// The terminator written on i_cfg_we (reset: carriage return) is latched
// into the text when the frame is taken.
// ----------------------------------------------------------------------------
module can_frame_ascii_encoder
    import acfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // frame input
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    // character output
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_item,
    // terminator register
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);

`include "can_frame_ascii_encoder_assert.svh"

    logic [7:0]            r_term;
    t_cell [NUM_CELLS-1:0] fmt_cells;
    t_cell [NUM_CELLS-1:0] cells;
    t_cell_ctrl            ctrl;
    logic                  head_free;

    // terminator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= TERM_RESET;
        end else if (i_cfg_we) begin
            r_term <= i_cfg_data;
        end
    end

    // head cell is free when empty or its character leaves this cycle
    assign head_free  = !cells[0].valid || i_ready;
    // text stays packed against the head, so only the head may still be busy
    assign o_ready    = !cells[1].valid && head_free;
    assign ctrl.load  = i_valid && o_ready;
    assign ctrl.shift = head_free;

    acfe_fmt u_fmt (
        .i_item  (i_item),
        .i_term  (r_term),
        .o_cells (fmt_cells)
    );

    // the chain: each cell takes its neighbor's character on a shift
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        t_cell next_cell;
        if (g == NUM_CELLS - 1) begin : g_tail
            assign next_cell = '0;
        end else begin : g_mid
            assign next_cell = cells[g+1];
        end
        acfe_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_load_cell (fmt_cells[g]),
            .i_next_cell (next_cell),
            .o_cell      (cells[g])
        );
    end

    assign o_valid          = cells[0].valid;
    assign o_item.out_char  = cells[0].ch;
    assign o_item.last_char = cells[0].last;

    // a taken frame puts its type letter at the head
    `ACFE_ASSERT_NXT(a_load_head, i_clk, i_rst_n, i_valid && o_ready, o_valid && !o_item.last_char)
    // no holes behind an empty head
    `ACFE_ASSERT_IMP(a_packed, i_clk, i_rst_n, !cells[0].valid, !cells[1].valid)
    // the terminator is the final occupied cell
    `ACFE_ASSERT_IMP(a_term_tail, i_clk, i_rst_n, o_valid && o_item.last_char, !cells[1].valid)

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the can frame ascii encoder: random frames and
// directed corner frames go in, every character coming out is compared with
// a text predicted from the frame and the current terminator setting
// ----------------------------------------------------------------------------
module tb_top;
    import acfe_pkg::*;

    localparam int HOLD_AT_CHAR   = 350;    // sink stalls for a long stretch here
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;     // longer than one full 27 char frame
    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transfer
    localparam int MAX_REPORTS    = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_item;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    // both sides run without gaps while set
    bit no_idle;

    // ------------------------------------------------------------------------
    // predicted character stream, one entry per output transfer
    // ------------------------------------------------------------------------
    class char_scoreboard;
        t_out_item  text_q[$];
        logic [7:0] term_char;
        int         mismatches;

        function new();
            term_char  = TERM_RESET;
            mismatches = 0;
        endfunction

        function void set_terminator(logic [7:0] c);
            term_char = c;
        endfunction

        function int pending();
            return text_q.size();
        endfunction

        function logic [7:0] hex_char(logic [3:0] n, bit upper);
            if (n < 4'd10)
                return CHAR_ZERO + 8'(n);
            return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(n - 4'd10);
        endfunction

        function void push(logic [7:0] c, logic last);
            t_out_item t;
            t.out_char  = c;
            t.last_char = last;
            text_q.push_back(t);
        endfunction

        // work out the whole text of one accepted frame
        function void note_frame(t_in_item f);
            logic [7:0]  payload [8];
            logic [31:0] id32;
            logic [3:0]  nbytes;
            bit          is_ext;
            bit          is_data;
            payload = '{f.data_byte_0, f.data_byte_1, f.data_byte_2, f.data_byte_3,
                        f.data_byte_4, f.data_byte_5, f.data_byte_6, f.data_byte_7};
            id32    = {3'b000, f.identifier};
            nbytes  = (f.data_length > MAX_BYTES) ? MAX_BYTES : f.data_length;
            is_ext  = (f.frame_type == FT_EXT_DATA) || (f.frame_type == FT_EXT_RMT);
            is_data = (f.frame_type == FT_EXT_DATA) || (f.frame_type == FT_STD_DATA);
            case (f.frame_type)
                FT_EXT_DATA: push(CHAR_EXT_DATA, 1'b0);
                FT_STD_DATA: push(CHAR_STD_DATA, 1'b0);
                FT_EXT_RMT:  push(CHAR_EXT_RMT, 1'b0);
                default:     push(CHAR_STD_RMT, 1'b0);
            endcase
            if (is_ext) begin
                for (int i = 7; i >= 0; i--)
                    push(hex_char(id32[i*4 +: 4], 1'b0), 1'b0);
            end else begin
                id32 = id32 & 32'h7FF;
                for (int i = 2; i >= 0; i--)
                    push(hex_char(id32[i*4 +: 4], 1'b0), 1'b0);
            end
            push(CHAR_ZERO + 8'(nbytes), 1'b0);
            if (is_data) begin
                for (int i = 0; i < int'(nbytes); i++) begin
                    push(hex_char(payload[i][7:4], 1'b1), 1'b0);
                    push(hex_char(payload[i][3:0], 1'b1), 1'b0);
                end
            end
            push(term_char, 1'b1);
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: %s  expected char %02h last %0b, got char %02h last %0b",
                         what, want.out_char, want.last_char, got.out_char, got.last_char);
        endfunction

        function void check_char(t_out_item got);
            t_out_item want;
            if (text_q.size() == 0) begin
                want = '0;
                report("character with nothing outstanding", want, got);
            end else begin
                want = text_q.pop_front();
                if (got.out_char !== want.out_char)
                    report("out_char", want, got);
                else if (got.last_char !== want.last_char)
                    report("last_char", want, got);
            end
        endfunction
    endclass

    char_scoreboard sb;

    can_frame_ascii_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // frame side driver: random gap, then hold valid until the transfer
    // ------------------------------------------------------------------------
    task automatic send_frame(input t_in_item f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        // valid only drops when a gap is wanted, so back to back frames keep it high
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= f;
        do @(posedge i_clk); while (!o_ready);
        sb.note_frame(f);
    endtask

    // mostly legal lengths, some above 8 to hit the saturation
    function automatic t_in_item random_frame();
        t_in_item f;
        f.frame_type  = t_frame_type'($urandom_range(0, 3));
        f.identifier  = 29'($urandom);
        f.data_length = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                                     : 4'($urandom_range(9, 15));
        f.data_byte_0 = 8'($urandom);
        f.data_byte_1 = 8'($urandom);
        f.data_byte_2 = 8'($urandom);
        f.data_byte_3 = 8'($urandom);
        f.data_byte_4 = 8'($urandom);
        f.data_byte_5 = 8'($urandom);
        f.data_byte_6 = 8'($urandom);
        f.data_byte_7 = 8'($urandom);
        return f;
    endfunction

    task automatic send_random(input int n);
        repeat (n) send_frame(random_frame());
    endtask

    // drop valid, wait for the text to finish, then let the chain go quiet
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_terminator(input logic [7:0] c);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_terminator(c);
    endtask

    // ------------------------------------------------------------------------
    // character side: random stall per character plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin : char_sink
        int  stall;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            // long stall so the chain fills and the frame side backs up
            if (!held && taken >= HOLD_AT_CHAR) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    // every character transfer is checked against the predicted text
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_char(o_item);
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_in_item f;
        int       failures;
        sb         = new();
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        // hold reset over rising edges, release it on a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames under the reset terminator (carriage return)
        // extended data, all zero identifier, empty payload
        f = '0;
        f.frame_type = FT_EXT_DATA;
        send_frame(f);
        // extended data, all ones identifier, full payload of ones
        f = '1;
        f.frame_type  = FT_EXT_DATA;
        f.data_length = 4'd8;
        send_frame(f);
        // standard data, top 11 bit identifier, full payload of zeros
        f = '0;
        f.frame_type  = FT_STD_DATA;
        f.identifier  = 29'h7FF;
        f.data_length = 4'd8;
        send_frame(f);
        // standard identifier with upper bits set: they must not show
        f.identifier  = 29'h1FFFF800 | 29'h5A5;
        f.data_length = 4'd3;
        f.data_byte_0 = 8'h0F;
        f.data_byte_1 = 8'hF0;
        f.data_byte_2 = 8'h9A;
        send_frame(f);
        // every hex digit in both cases
        f.frame_type  = FT_EXT_DATA;
        f.identifier  = 29'h0ABCDEF9;
        f.data_length = 4'd8;
        {f.data_byte_0, f.data_byte_1, f.data_byte_2, f.data_byte_3,
         f.data_byte_4, f.data_byte_5, f.data_byte_6, f.data_byte_7} = 64'h0123456789ABCDEF;
        send_frame(f);
        f.identifier  = 29'h12345678;
        {f.data_byte_0, f.data_byte_1, f.data_byte_2, f.data_byte_3,
         f.data_byte_4, f.data_byte_5, f.data_byte_6, f.data_byte_7} = 64'hFEDCBA9876543210;
        send_frame(f);
        // remote frames keep the length digit but drop the payload
        f.frame_type  = FT_EXT_RMT;
        f.identifier  = 29'h1FFFFFFF;
        send_frame(f);
        f.frame_type  = FT_STD_RMT;
        f.identifier  = 29'h00000123;
        f.data_length = 4'd0;
        send_frame(f);
        f.identifier  = 29'h1FFFFFFF;
        f.data_length = 4'd5;
        send_frame(f);
        // length above 8 saturates, data and remote alike
        f.frame_type  = FT_STD_DATA;
        f.data_length = 4'd9;
        send_frame(f);
        f.frame_type  = FT_EXT_DATA;
        f.data_length = 4'd15;
        send_frame(f);
        f.frame_type  = FT_EXT_RMT;
        f.data_length = 4'd12;
        send_frame(f);
        f.frame_type  = FT_STD_RMT;
        f.data_length = 4'd15;
        send_frame(f);
        // single byte frames of each data type
        f.frame_type  = FT_STD_DATA;
        f.identifier  = 29'h0;
        f.data_length = 4'd1;
        f.data_byte_0 = 8'hA5;
        send_frame(f);
        f.frame_type  = FT_EXT_DATA;
        send_frame(f);
        drain();

        // terminator at its low extreme
        write_terminator(8'h00);
        send_random(27);
        drain();

        // high extreme, back to back traffic on both sides
        write_terminator(8'hFF);
        no_idle = 1'b1;
        send_random(27);
        drain();

        no_idle = 1'b0;
        write_terminator(8'($urandom));
        send_random(27);
        drain();

        // line feed, a common alternative
        write_terminator(8'h0A);
        send_random(27);
        drain();

        failures = sb.mismatches + sb.pending();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
